// ===== sv/gab_pkg.sv =====
package gab_pkg;

  // default fraction bits of the linear-light values
  localparam int unsigned LINEAR_FRAC_BITS = 16;

  // channel layout: 0 = blue, 1 = green, 2 = red, 3 = alpha
  localparam int unsigned NUM_COLOURS = 3;
  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned ALPHA_CH    = 3;

  // opacity register
  localparam int unsigned SCALE_WIDTH = 9;
  localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = 9'd256;
  localparam int unsigned SCALE_SHIFT = 8;
  localparam int unsigned SCALE_ROUND = 128;

  // square root search: one result bit per stage
  localparam int unsigned ROOT_BITS = 8;
  localparam int unsigned Q_WIDTH   = 20;
  localparam logic [17:0] ROOT_SCALE = 18'd260100;  // 4 * 255^2

  localparam logic [7:0] CHANNEL_MAX = 8'hFF;
  localparam logic [7:0] ALPHA_GAIN  = 8'd255;

  // linearize plus four blend stages plus the root search
  localparam int unsigned PIPE_LATENCY = 5 + ROOT_BITS;

  // table denominators, 2 * 255^2 and 2 * 255
  localparam longint unsigned COLOUR_DEN = 130050;
  localparam longint unsigned ALPHA_DEN  = 510;

  // partial result carried down the root search
  typedef struct packed {
    logic [NUM_COLOURS-1:0][Q_WIDTH-1:0] q;
    logic [NUM_COLOURS-1:0][7:0]         n;
    logic [7:0]                          alpha;
  } root_state_t;

  // round(c^2 * 2^f / 255^2), evaluated at elaboration only
  function automatic longint unsigned lin_colour(input int unsigned c, input int unsigned f);
    longint unsigned num;
    num = (64'(c) * 64'(c)) << (f + 1);
    return (num + COLOUR_DEN / 2) / COLOUR_DEN;
  endfunction

  // round(a * 2^f / 255), evaluated at elaboration only
  function automatic longint unsigned lin_alpha(input int unsigned a, input int unsigned f);
    longint unsigned num;
    num = 64'(a) << (f + 1);
    return (num + ALPHA_DEN / 2) / ALPHA_DEN;
  endfunction

endpackage

// ===== sv/gab_linearize.sv =====
module gab_linearize #(
  parameter int unsigned FRAC_BITS = gab_pkg::LINEAR_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          source_pixel,
  input  logic [31:0]          dest_pixel,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   src_lin [gab_pkg::CHANNELS],
  output logic [FRAC_BITS:0]   dst_lin [gab_pkg::CHANNELS]
);

  localparam int unsigned LW = FRAC_BITS + 1;

  logic [FRAC_BITS:0] colour_lut [256];
  logic [FRAC_BITS:0] alpha_lut  [256];

  // constant lookup tables for 8-bit to linear conversion
  for (genvar i = 0; i < 256; i++) begin : g_lut
    localparam logic [FRAC_BITS:0] COLOUR_VAL = LW'(gab_pkg::lin_colour(i, FRAC_BITS));
    localparam logic [FRAC_BITS:0] ALPHA_VAL  = LW'(gab_pkg::lin_alpha(i, FRAC_BITS));
    assign colour_lut[i] = COLOUR_VAL;
    assign alpha_lut[i]  = ALPHA_VAL;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // table reads for all eight channels
  always_ff @(posedge clk) begin
    for (int k = 0; k < gab_pkg::NUM_COLOURS; k++) begin
      src_lin[k] <= colour_lut[source_pixel[8*k +: 8]];
      dst_lin[k] <= colour_lut[dest_pixel[8*k +: 8]];
    end
    src_lin[gab_pkg::ALPHA_CH] <= alpha_lut[source_pixel[31:24]];
    dst_lin[gab_pkg::ALPHA_CH] <= alpha_lut[dest_pixel[31:24]];
  end

endmodule

// ===== sv/gab_blend.sv =====
module gab_blend #(
  parameter int unsigned FRAC_BITS = gab_pkg::LINEAR_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [gab_pkg::SCALE_WIDTH-1:0]     scale,
  input  logic [FRAC_BITS:0]                  src_lin [gab_pkg::CHANNELS],
  input  logic [FRAC_BITS:0]                  dst_lin [gab_pkg::CHANNELS],
  output logic                                out_valid,
  output gab_pkg::root_state_t                out_state
);

  localparam int unsigned LW = FRAC_BITS + 1;
  localparam int unsigned PW = LW + gab_pkg::SCALE_WIDTH;
  localparam int unsigned MW = 2 * LW;
  localparam int unsigned XW = FRAC_BITS + 2;
  localparam int unsigned RW = XW + 18;
  localparam int unsigned AW = XW + 8;
  localparam logic [LW-1:0] ONE       = LW'(1) << FRAC_BITS;
  localparam logic [MW-1:0] PROD_HALF = MW'(1) << (FRAC_BITS - 1);
  localparam logic [AW-1:0] ALPHA_HALF = AW'(1) << (FRAC_BITS - 1);

  logic          a_valid, b_valid, c_valid;
  logic [LW-1:0] a_src [gab_pkg::CHANNELS];
  logic [LW-1:0] a_dst [gab_pkg::CHANNELS];
  logic [MW-1:0] b_prod [gab_pkg::CHANNELS];
  logic [LW-1:0] b_src [gab_pkg::CHANNELS];
  logic [XW-1:0] c_x [gab_pkg::CHANNELS];

  logic [PW-1:0] scaled_full [gab_pkg::CHANNELS];
  logic [LW-1:0] inv;
  logic [MW-1:0] rounded [gab_pkg::CHANNELS];
  logic [RW-1:0] rhs [gab_pkg::NUM_COLOURS];
  logic [AW-1:0] alpha_full;
  logic [9:0]    alpha_int;

  // valid bits of the four stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // stage a: global opacity on the source channels
  always_comb begin
    for (int k = 0; k < gab_pkg::CHANNELS; k++) begin
      scaled_full[k] = PW'(src_lin[k]) * PW'(scale) + PW'(gab_pkg::SCALE_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < gab_pkg::CHANNELS; k++) begin
      a_src[k] <= scaled_full[k][gab_pkg::SCALE_SHIFT +: LW];
      a_dst[k] <= dst_lin[k];
    end
  end

  // stage b: destination times one minus source alpha
  assign inv = (a_src[gab_pkg::ALPHA_CH] >= ONE) ? '0 : ONE - a_src[gab_pkg::ALPHA_CH];

  always_ff @(posedge clk) begin
    for (int k = 0; k < gab_pkg::CHANNELS; k++) begin
      b_prod[k] <= MW'(inv) * MW'(a_dst[k]);
      b_src[k]  <= a_src[k];
    end
  end

  // stage c: round the product and add the source
  always_comb begin
    for (int k = 0; k < gab_pkg::CHANNELS; k++) begin
      rounded[k] = b_prod[k] + PROD_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < gab_pkg::CHANNELS; k++) begin
      c_x[k] <= XW'(rounded[k] >> FRAC_BITS) + XW'(b_src[k]);
    end
  end

  // stage d: root operand for colour, back to 8 bits for alpha
  always_comb begin
    for (int k = 0; k < gab_pkg::NUM_COLOURS; k++) begin
      rhs[k] = RW'(c_x[k]) * RW'(gab_pkg::ROOT_SCALE);
    end
    alpha_full = AW'(c_x[gab_pkg::ALPHA_CH]) * AW'(gab_pkg::ALPHA_GAIN) + ALPHA_HALF;
    alpha_int  = alpha_full[FRAC_BITS +: 10];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < gab_pkg::NUM_COLOURS; k++) begin
      out_state.q[k] <= rhs[k][FRAC_BITS +: gab_pkg::Q_WIDTH];
      out_state.n[k] <= '0;
    end
    out_state.alpha <= (alpha_int > 10'(gab_pkg::CHANNEL_MAX)) ? gab_pkg::CHANNEL_MAX
                                                               : alpha_int[7:0];
  end

endmodule

// ===== sv/gab_root_step.sv =====
module gab_root_step #(
  parameter int unsigned BIT = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  gab_pkg::root_state_t in_state,
  output logic                 out_valid,
  output gab_pkg::root_state_t out_state
);

  localparam logic [7:0] TRIAL_BIT = 8'(1) << BIT;
  localparam logic [7:0] LOW_MASK  = 8'((1 << BIT) - 1);

  logic [7:0]  trial [gab_pkg::NUM_COLOURS];
  logic [8:0]  odd   [gab_pkg::NUM_COLOURS];
  logic [17:0] sq    [gab_pkg::NUM_COLOURS];
  gab_pkg::root_state_t state_next;

  // try this bit: keep it when (2n-1)^2 stays within the operand
  always_comb begin
    state_next = in_state;
    for (int k = 0; k < gab_pkg::NUM_COLOURS; k++) begin
      trial[k] = in_state.n[k] | TRIAL_BIT;
      odd[k]   = {trial[k], 1'b0} - 9'd1;
      sq[k]    = 18'(odd[k]) * 18'(odd[k]);
      if (20'(sq[k]) <= in_state.q[k]) begin
        state_next.n[k] = trial[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= state_next;
  end

  // bits below this stage are still undecided and must be clear
  a_low_bits_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_state.n[0] | out_state.n[1] | out_state.n[2]) & LOW_MASK) == 8'd0)
    else $error("root search set a bit below its stage");

endmodule

// ===== sv/gamma_alpha_blend_pixel.sv =====
// Premultiplied ARGB8888 "over" blend in approximate linear light (gamma 2).
// One pixel pair is taken per clock whenever busy is low; busy is high only
// during reset. Each item gives one blended pixel on blended_pixel, marked
// by done for one cycle, after one stage of table lookup, four blend stages
// (opacity multiply, destination multiply, sum, output scaling) and eight
// stages of the square root search, one result bit each. The receiver
// cannot stall, so results must be taken as they come. The user must write
// alpha_scale (reset 256) over the cfg channel only while no pixel is in
// flight; the block does not enforce this. Values above 256 act as 256.
module gamma_alpha_blend_pixel #(
  parameter int unsigned LINEAR_FRAC_BITS = gab_pkg::LINEAR_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_pixel,
  input  logic [31:0] dest_pixel,
  output logic        done,
  output logic [31:0] blended_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  logic [gab_pkg::SCALE_WIDTH-1:0] alpha_scale;
  logic [gab_pkg::SCALE_WIDTH-1:0] scale_eff;
  logic                            accept;

  logic                       lin_valid;
  logic [LINEAR_FRAC_BITS:0]  src_lin [gab_pkg::CHANNELS];
  logic [LINEAR_FRAC_BITS:0]  dst_lin [gab_pkg::CHANNELS];

  logic                 root_valid [gab_pkg::ROOT_BITS+1];
  gab_pkg::root_state_t root_state [gab_pkg::ROOT_BITS+1];

  // handshakes
  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  // opacity register; the value used is saturated at one
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_scale <= gab_pkg::SCALE_ONE;
    end else if (cfg_valid && cfg_ready) begin
      alpha_scale <= cfg_data;
    end
  end

  assign scale_eff = (alpha_scale > gab_pkg::SCALE_ONE) ? gab_pkg::SCALE_ONE : alpha_scale;

  gab_linearize #(
    .FRAC_BITS (LINEAR_FRAC_BITS)
  ) u_linearize (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .source_pixel (source_pixel),
    .dest_pixel   (dest_pixel),
    .out_valid    (lin_valid),
    .src_lin      (src_lin),
    .dst_lin      (dst_lin)
  );

  gab_blend #(
    .FRAC_BITS (LINEAR_FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lin_valid),
    .scale     (scale_eff),
    .src_lin   (src_lin),
    .dst_lin   (dst_lin),
    .out_valid (root_valid[0]),
    .out_state (root_state[0])
  );

  // square root search, most significant bit first
  for (genvar j = 0; j < gab_pkg::ROOT_BITS; j++) begin : g_root
    gab_root_step #(
      .BIT (gab_pkg::ROOT_BITS - 1 - j)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (root_valid[j]),
      .in_state  (root_state[j]),
      .out_valid (root_valid[j+1]),
      .out_state (root_state[j+1])
    );
  end

  // result item
  assign done          = root_valid[gab_pkg::ROOT_BITS];
  assign blended_pixel = {root_state[gab_pkg::ROOT_BITS].alpha,
                          root_state[gab_pkg::ROOT_BITS].n[2],
                          root_state[gab_pkg::ROOT_BITS].n[1],
                          root_state[gab_pkg::ROOT_BITS].n[0]};

  // every result comes from an item taken a fixed latency earlier
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, gab_pkg::PIPE_LATENCY))
    else $error("result without a matching item");

  // black transparent over black stays black
  a_zero_blend: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && source_pixel == 32'd0 && dest_pixel == 32'd0,
                   gab_pkg::PIPE_LATENCY)) |-> blended_pixel == 32'd0)
    else $error("zero pixels did not blend to zero");

endmodule

// ===== verif/testbench.sv =====
module testbench;

  localparam int unsigned FRAC    = gab_pkg::LINEAR_FRAC_BITS;
  localparam int unsigned LATENCY = gab_pkg::PIPE_LATENCY;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] source_pixel;
  logic [31:0] dest_pixel;
  logic        done;
  logic [31:0] blended_pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  // blended pixels predicted for items in flight, oldest first
  logic [31:0] pending_pixels[$];
  logic [8:0]  opacity_reg;
  logic [31:0] wanted_pixel;
  bit          idle_enable;
  int          sent_count;
  int          checked_count;
  int          fail_count;
  int          settings_count;

  gamma_alpha_blend_pixel dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .source_pixel (source_pixel),
    .dest_pixel   (dest_pixel),
    .done         (done),
    .blended_pixel(blended_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // colour channel to linear light, round(c^2 * 2^F / 255^2)
  function automatic longint unsigned colour_lin(logic [7:0] c);
    longint unsigned num;
    num = (64'(c) * 64'(c)) << (FRAC + 1);
    return (num + 65025) / 130050;
  endfunction

  // alpha to linear, round(a * 2^F / 255)
  function automatic longint unsigned alpha_lin(logic [7:0] a);
    longint unsigned num;
    num = 64'(a) << (FRAC + 1);
    return (num + 255) / 510;
  endfunction

  function automatic longint unsigned scale_by(longint unsigned v, longint unsigned s);
    return (v * s + 128) >> 8;
  endfunction

  // (1 - src_a) * dst + src in linear fixed point
  function automatic longint unsigned over_sum(longint unsigned src, longint unsigned dst,
                                               longint unsigned src_a);
    longint unsigned one;
    longint unsigned inv;
    one = 64'd1 << FRAC;
    inv = (src_a >= one) ? 64'd0 : one - src_a;
    return ((inv * dst + (one >> 1)) >> FRAC) + src;
  endfunction

  // largest n with n <= 255*sqrt(x) + 1/2, exact integer search
  function automatic logic [7:0] colour_out(longint unsigned x);
    longint unsigned rhs;
    longint unsigned odd;
    logic [7:0]      n;
    int              k;
    rhs = x * 260100;
    n   = 8'd0;
    for (k = 1; k <= 255; k++) begin
      odd = 64'(2 * k - 1);
      if (((odd * odd) << FRAC) <= rhs) n = 8'(k);
    end
    return n;
  endfunction

  function automatic logic [7:0] alpha_out(longint unsigned x);
    longint unsigned v;
    v = (x * 255 + (64'd1 << (FRAC - 1))) >> FRAC;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // full pixel: opacity, over blend and return to 8 bits per channel
  function automatic logic [31:0] blend_over(logic [31:0] sp, logic [31:0] dp, logic [8:0] reg_val);
    longint unsigned s;
    longint unsigned sa;
    longint unsigned da;
    longint unsigned sc;
    longint unsigned dc;
    logic [31:0]     res;
    int              ch;
    s   = (reg_val > 9'd256) ? 64'd256 : 64'(reg_val);
    sa  = scale_by(alpha_lin(sp[31:24]), s);
    da  = alpha_lin(dp[31:24]);
    res = '0;
    res[31:24] = alpha_out(over_sum(sa, da, sa));
    for (ch = 0; ch < 3; ch++) begin
      sc = scale_by(colour_lin(sp[ch*8 +: 8]), s);
      dc = colour_lin(dp[ch*8 +: 8]);
      res[ch*8 +: 8] = colour_out(over_sum(sc, dc, sa));
    end
    return res;
  endfunction

  // mostly premultiplied pixels, some with alpha at the ends, some fully random
  function automatic logic [31:0] random_argb();
    logic [7:0]  a;
    logic [31:0] px;
    int unsigned kind;
    kind = $urandom_range(9);
    a    = 8'($urandom);
    px   = $urandom;
    if (kind < 6) begin
      px = {a, 8'($urandom_range(a)), 8'($urandom_range(a)), 8'($urandom_range(a))};
    end else if (kind == 6) begin
      px[31:24] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  function automatic logic [8:0] random_opacity();
    int unsigned kind;
    kind = $urandom_range(3);
    case (kind)
      0: begin
        return ($urandom_range(1)) ? 9'd0 : 9'd511;
      end
      1: begin
        return 9'($urandom_range(511, 257));
      end
      default: begin
        return 9'($urandom_range(256));
      end
    endcase
  endfunction

  task automatic report_failure(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected %08h got %08h (item %0d)", what, want, got, checked_count);
  endtask

  // check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_failure("result with nothing pending", 32'h0, blended_pixel);
      end else begin
        wanted_pixel = pending_pixels.pop_front();
        if (blended_pixel !== wanted_pixel)
          report_failure("blended pixel mismatch", wanted_pixel, blended_pixel);
      end
      checked_count++;
    end
  end

  // send one item, now and then with start held low ahead of it when idling is on
  task automatic push_pixel(logic [31:0] sp, logic [31:0] dp);
    if (idle_enable && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    source_pixel <= sp;
    dest_pixel   <= dp;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.push_back(blend_over(sp, dp, opacity_reg));
    sent_count++;
  endtask

  // stop sending and let the pipeline empty
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_pixels.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      $display("%0d results never arrived", pending_pixels.size());
      fail_count += pending_pixels.size();
      pending_pixels.delete();
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_opacity(logic [8:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    opacity_reg = v;
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // corners at reset opacity: zero, full, colour above alpha, tiny values
  task automatic test_corner_pixels();
    push_pixel(32'h00000000, 32'h00000000);
    push_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
    push_pixel(32'h00000000, 32'hFFFFFFFF);
    push_pixel(32'hFFFFFFFF, 32'h00000000);
    push_pixel(32'h00FFFFFF, 32'hFFFFFFFF);
    push_pixel(32'h80FF00FF, 32'h00808080);
    push_pixel(32'h80404040, 32'hFF102030);
    push_pixel(32'h01010101, 32'hFEFEFEFE);
    push_pixel(32'h7F7F7F7F, 32'h80808080);
    push_pixel(32'hFF000000, 32'hFFFFFFFF);
    push_pixel(32'h00000000, 32'h80FF8000);
  endtask

  // opacity at its ends and just past one, where it saturates
  task automatic test_opacity_extremes();
    logic [8:0] levels[6];
    int         i;
    levels = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd257, 9'd511};
    for (i = 0; i < 6; i++) begin
      write_opacity(levels[i]);
      push_pixel(32'hFFFFFFFF, 32'h00000000);
      push_pixel(32'h80808080, 32'hFF204060);
    end
  endtask

  // back-to-back items, no gaps
  task automatic test_random_stream();
    int i;
    idle_enable = 1'b0;
    write_opacity(random_opacity());
    for (i = 0; i < 150; i++) push_pixel(random_argb(), $urandom);
  endtask

  // random gaps, opacity changed per phase, one full drain mid-phase
  task automatic test_random_gaps();
    int phase;
    int i;
    idle_enable = 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      write_opacity(random_opacity());
      for (i = 0; i < 100; i++) begin
        if (i == 50) settle();
        push_pixel(random_argb(), $urandom);
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    source_pixel <= '0;
    dest_pixel   <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    opacity_reg    = 9'd256;
    idle_enable    = 1'b0;
    sent_count     = 0;
    checked_count  = 0;
    fail_count     = 0;
    settings_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_pixels();
    test_opacity_extremes();
    test_random_stream();
    test_random_gaps();
    settle();

    $display("sent %0d pixel pairs, checked %0d blended pixels", sent_count, checked_count);
    $display("opacity written %0d times, incl. 0, 1, 256 and saturating values", settings_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
